FILE: design/v3alu_pkg.sv
// Shared types, codes and helpers for the three-component vector unit.
`default_nettype none

package v3alu_pkg;

   // Default fraction width of the fixed-point format
   localparam int unsigned FRAC_BITS_DEF = 16;

   // Pipeline depths of the iterative units
   localparam int unsigned SQRT_STAGES = 32;
   localparam int unsigned DIV_STAGES  = 33;

   // Width of intermediate sums ahead of saturation
   localparam int unsigned SAT_W = 68;

   // Operation codes
   localparam logic [3:0] MODE_ADD     = 4'd0;
   localparam logic [3:0] MODE_SUB     = 4'd1;
   localparam logic [3:0] MODE_NEG     = 4'd2;
   localparam logic [3:0] MODE_SCALE   = 4'd3;
   localparam logic [3:0] MODE_DIV     = 4'd4;
   localparam logic [3:0] MODE_DOT     = 4'd5;
   localparam logic [3:0] MODE_LENSQ   = 4'd6;
   localparam logic [3:0] MODE_LEN     = 4'd7;
   localparam logic [3:0] MODE_NORM    = 4'd8;
   localparam logic [3:0] MODE_CROSS   = 4'd9;
   localparam logic [3:0] MODE_REFLECT = 4'd10;
   localparam logic [3:0] MODE_NEAR    = 4'd11;

   // Status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   // Saturation limits
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_x;
      logic signed [31:0] res_y;
      logic signed [31:0] res_z;
      logic signed [31:0] res_scalar;
      logic               is_near_zero;
      logic [1:0]         status;
   } rsp_type;

   // What one lane hands to the merge stage
   typedef struct packed {
      logic signed [63:0] p;
      logic signed [63:0] q;
      logic [31:0]        simple;
      logic               ovf;
      logic               under_limit;
   } lane_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ovf;
   } sat_type;

   // Side data carried through the square root pipeline
   typedef struct packed {
      logic [3:0]       mode;
      logic [2:0][31:0] a;
      logic [31:0]      s;
      logic [2:0][31:0] r;
      logic [31:0]      rs;
      logic             sat;
      logic             nz;
   } sq_pay_type;

   // Side data carried through the divider pipeline
   typedef struct packed {
      logic [3:0]       mode;
      logic [2:0][31:0] r;
      logic [31:0]      rs;
      logic             sat;
      logic             nz;
      logic             dz;
   } div_pay_type;

   // Clamp a wide signed value to 32 bits
   function automatic sat_type sat32(input logic [SAT_W-1:0] v);
      sat_type res;
      res.ovf = !((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]));
      if (res.ovf) begin
         res.val = v[SAT_W-1] ? Q_MIN : Q_MAX;
      end else begin
         res.val = v[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: design/v3alu_lane.sv
// One component lane: add/sub/negate, two products and the near-zero compare.
`default_nettype none

module v3alu_lane (
   input  wire logic                clock,
   input  wire logic [3:0]          mode,
   input  wire logic signed [31:0]  a_i,
   input  wire logic signed [31:0]  b_i,
   input  wire logic signed [31:0]  a_j,
   input  wire logic signed [31:0]  b_j,
   input  wire logic signed [31:0]  a_k,
   input  wire logic signed [31:0]  b_k,
   input  wire logic signed [31:0]  s,
   input  wire logic [30:0]         limit,
   output v3alu_pkg::lane_type      lane_out
);

   localparam int unsigned SW = v3alu_pkg::SAT_W;

   logic signed [31:0]   m1a, m1b, m2a, m2b;
   logic signed [32:0]   simple_w;
   logic [31:0]          mag;
   v3alu_pkg::sat_type   simple_sat;
   v3alu_pkg::lane_type  lane_in;
   v3alu_pkg::lane_type  lane_ff;

   // Operand selection per operation
   always_comb begin
      m1a      = a_i;
      m1b      = b_i;
      m2a      = '0;
      m2b      = '0;
      simple_w = '0;
      case (mode)
         v3alu_pkg::MODE_ADD:   simple_w = 33'(a_i) + 33'(b_i);
         v3alu_pkg::MODE_SUB:   simple_w = 33'(a_i) - 33'(b_i);
         v3alu_pkg::MODE_NEG:   simple_w = -33'(a_i);
         v3alu_pkg::MODE_SCALE: m1b = s;
         v3alu_pkg::MODE_LENSQ, v3alu_pkg::MODE_LEN, v3alu_pkg::MODE_NORM: begin
            m1b = a_i;
         end
         v3alu_pkg::MODE_CROSS: begin
            m1a = a_j;
            m1b = b_k;
            m2a = a_k;
            m2b = b_j;
         end
         default: ;
      endcase
   end

   // Products, clamped simple result, magnitude compare
   always_comb begin
      simple_sat          = v3alu_pkg::sat32(SW'(simple_w));
      mag                 = a_i[31] ? (~a_i + 32'd1) : a_i;
      lane_in.p           = 64'(m1a) * 64'(m1b);
      lane_in.q           = 64'(m2a) * 64'(m2b);
      lane_in.simple      = simple_sat.val;
      lane_in.ovf         = simple_sat.ovf;
      lane_in.under_limit = mag < {1'b0, limit};
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

FILE: design/v3alu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module v3alu_sqrt (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [63:0]             radicand,
   input  wire v3alu_pkg::sq_pay_type   in_pay,
   output logic                         out_valid,
   output logic [31:0]                  root,
   output v3alu_pkg::sq_pay_type        out_pay
);

   localparam int unsigned N = v3alu_pkg::SQRT_STAGES;

   logic                  v_ff    [N];
   logic [33:0]           rem_ff  [N];
   logic [31:0]           root_ff [N];
   logic [63:0]           rad_ff  [N];
   v3alu_pkg::sq_pay_type pay_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                  v_prev;
      logic [33:0]           rem_prev;
      logic [31:0]           root_prev;
      logic [63:0]           rad_prev;
      v3alu_pkg::sq_pay_type pay_prev;
      logic [35:0]           cur;
      logic [35:0]           trial;
      logic [33:0]           rem_in;
      logic [31:0]           root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
         assign pay_prev  = in_pay;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign pay_prev  = pay_ff[k-1];
      end

      // Bring down two radicand bits, try root*4+1
      always_comb begin
         cur   = {rem_prev, rad_prev[63:62]};
         trial = {2'b00, root_prev, 2'b01};
         if (cur >= trial) begin
            rem_in  = 34'(cur - trial);
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = cur[33:0];
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= {rad_prev[61:0], 2'b00};
         pay_ff[k]  <= pay_prev;
      end
   end

   assign out_valid = v_ff[N-1];
   assign root      = root_ff[N-1];
   assign out_pay   = pay_ff[N-1];

endmodule

`default_nettype wire

FILE: design/v3alu_div.sv
// Pipelined three-lane fixed-point divider, one quotient bit per stage.
`default_nettype none

module v3alu_div #(
   parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [2:0][31:0]         num,
   input  wire logic [31:0]              den,
   input  wire logic                     den_neg,
   input  wire v3alu_pkg::div_pay_type   in_pay,
   output logic                          out_valid,
   output logic [2:0][31:0]              quo,
   output logic [2:0]                    qsat,
   output v3alu_pkg::div_pay_type        out_pay
);

   localparam int unsigned N  = v3alu_pkg::DIV_STAGES;
   localparam int unsigned NW = 32 + FRAC_BITS;

   logic [2:0][31:0] rem0;
   logic [2:0][32:0] lo0;
   logic [2:0]       over0;
   logic [2:0]       neg0;

   logic                   v_ff    [N];
   v3alu_pkg::div_pay_type pay_ff  [N];
   logic [31:0]            den_ff  [N];
   logic [2:0][31:0]       rem_ff  [N];
   logic [2:0][32:0]       q_ff    [N];
   logic [2:0][32:0]       lo_ff   [N];
   logic [2:0]             over_ff [N];
   logic [2:0]             neg_ff  [N];

   // Dividend magnitude shifted up; quotients of 2^33 or more flag at once
   always_comb begin
      logic [31:0]   mag;
      logic [NW-1:0] wide;
      for (int l = 0; l < 3; l++) begin
         mag      = num[l][31] ? (~num[l] + 32'd1) : num[l];
         wide     = {mag, {FRAC_BITS{1'b0}}};
         rem0[l]  = 32'(wide[NW-1:33]);
         lo0[l]   = wide[32:0];
         over0[l] = 32'(wide[NW-1:33]) >= den;
         neg0[l]  = num[l][31] ^ den_neg;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                   v_prev;
      v3alu_pkg::div_pay_type pay_prev;
      logic [31:0]            den_prev;
      logic [2:0][31:0]       rem_prev;
      logic [2:0][32:0]       q_prev;
      logic [2:0][32:0]       lo_prev;
      logic [2:0]             over_prev;
      logic [2:0]             neg_prev;
      logic [2:0][31:0]       rem_in;
      logic [2:0][32:0]       q_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign pay_prev  = in_pay;
         assign den_prev  = den;
         assign rem_prev  = rem0;
         assign q_prev    = '0;
         assign lo_prev   = lo0;
         assign over_prev = over0;
         assign neg_prev  = neg0;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign pay_prev  = pay_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign lo_prev   = lo_ff[k-1];
         assign over_prev = over_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
      end

      // Restoring step in each lane
      always_comb begin
         logic [32:0] cur;
         logic        ge;
         for (int l = 0; l < 3; l++) begin
            cur       = {rem_prev[l], lo_prev[l][32]};
            ge        = cur >= {1'b0, den_prev};
            rem_in[l] = ge ? 32'(cur - {1'b0, den_prev}) : cur[31:0];
            q_in[l]   = {q_prev[l][31:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         pay_ff[k]  <= pay_prev;
         den_ff[k]  <= den_prev;
         rem_ff[k]  <= rem_in;
         q_ff[k]    <= q_in;
         over_ff[k] <= over_prev;
         neg_ff[k]  <= neg_prev;
         for (int l = 0; l < 3; l++) begin
            lo_ff[k][l] <= {lo_prev[l][31:0], 1'b0};
         end
      end
   end

   // Apply sign and clamp
   always_comb begin
      logic [32:0] q;
      for (int l = 0; l < 3; l++) begin
         q = q_ff[N-1][l];
         if (neg_ff[N-1][l]) begin
            qsat[l] = over_ff[N-1][l] | q[32] | (q[31] & (|q[30:0]));
            quo[l]  = qsat[l] ? v3alu_pkg::Q_MIN : (~q[31:0] + 32'd1);
         end else begin
            qsat[l] = over_ff[N-1][l] | q[32] | q[31];
            quo[l]  = qsat[l] ? v3alu_pkg::Q_MAX : q[31:0];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_pay   = pay_ff[N-1];

endmodule

`default_nettype wire

FILE: design/vector3_alu.sv
// Top level of the fixed-point three-component vector unit.
// One operation is accepted every cycle; busy never rises.
// Each result strobes on rsp_valid after its accepting edge, passing the lanes, merge,
// reflect product, 32-stage square root, 33-stage divider and output register in turn.
// Every operation takes the same path, so results leave in order, one per cycle at most.
// Reset clears the pipeline valid bits and sets the threshold register limit_ff to 1.
`default_nettype none

module vector3_alu #(
   parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF  // 8 to 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire v3alu_pkg::req_type   req_data,
   output logic                      rsp_valid,
   output v3alu_pkg::rsp_type        rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [30:0]          csr_data
);

   localparam int unsigned SW      = v3alu_pkg::SAT_W;
   localparam int unsigned LATENCY = 3 + v3alu_pkg::SQRT_STAGES + v3alu_pkg::DIV_STAGES + 1;

   logic [30:0] limit_ff;
   logic        accept;

   logic [2:0][31:0] a_req, b_req;

   // stage 1
   logic                v1_ff;
   logic [3:0]          mode1_ff;
   logic [2:0][31:0]    a1_ff, b1_ff;
   logic [31:0]         s1_ff;
   v3alu_pkg::lane_type lane [3];

   // stage 2
   logic [SW-1:0]       sum_w, dot_w;
   v3alu_pkg::sat_type  dot_s, t_s;
   v3alu_pkg::sat_type  scale_s [3];
   v3alu_pkg::sat_type  cross_s [3];
   logic [2:0][31:0]    r2_in;
   logic [31:0]         rs2_in;
   logic                sat2_in, nz2_in;
   logic                v2_ff;
   logic [3:0]          mode2_ff;
   logic [2:0][31:0]    a2_ff, b2_ff, r2_ff;
   logic [31:0]         s2_ff, rs2_ff, t2_ff;
   logic                sat2_ff, nz2_ff;
   logic [63:0]         sq2_ff;

   // stage 3
   logic [2:0][63:0]    rp3_in;
   logic                v3_ff;
   logic [3:0]          mode3_ff;
   logic [2:0][31:0]    a3_ff, r3_ff;
   logic [31:0]         s3_ff, rs3_ff;
   logic                sat3_ff, nz3_ff;
   logic [63:0]         sq3_ff;
   logic [2:0][63:0]    rp3_ff;

   // square root and divider
   v3alu_pkg::sat_type     refl_s [3];
   v3alu_pkg::sq_pay_type  sq_in_pay, sq_out_pay;
   logic                   sq_valid;
   logic [31:0]            root;
   logic [31:0]            s_mag, den;
   logic                   den_neg;
   v3alu_pkg::div_pay_type dv_in_pay, dv_out_pay;
   logic                   dv_valid;
   logic [2:0][31:0]       quo;
   logic [2:0]             qsat;

   // output
   v3alu_pkg::rsp_type rsp_in, rsp_data_ff;
   logic               rsp_valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 31'd1;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   assign a_req = {req_data.a_z, req_data.a_y, req_data.a_x};
   assign b_req = {req_data.b_z, req_data.b_y, req_data.b_x};

   // Lanes, one per component
   for (genvar l = 0; l < 3; l++) begin : g_lane
      v3alu_lane u_lane (
         .clock    (clock),
         .mode     (req_data.mode),
         .a_i      ($signed(a_req[l])),
         .b_i      ($signed(b_req[l])),
         .a_j      ($signed(a_req[(l+1)%3])),
         .b_j      ($signed(b_req[(l+1)%3])),
         .a_k      ($signed(a_req[(l+2)%3])),
         .b_k      ($signed(b_req[(l+2)%3])),
         .s        (req_data.scalar_in),
         .limit    (limit_ff),
         .lane_out (lane[l])
      );
   end

   // Stage 1 side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      mode1_ff <= req_data.mode;
      a1_ff    <= a_req;
      b1_ff    <= b_req;
      s1_ff    <= req_data.scalar_in;
   end

   // Merge: dot sum, shifts and clamps, result selection
   always_comb begin
      sum_w = SW'($signed(lane[0].p)) + SW'($signed(lane[1].p)) + SW'($signed(lane[2].p));
      dot_w = SW'($signed(sum_w) >>> FRAC_BITS);
      dot_s = v3alu_pkg::sat32(dot_w);
      t_s   = v3alu_pkg::sat32({dot_w[SW-2:0], 1'b0});
      for (int l = 0; l < 3; l++) begin
         scale_s[l] = v3alu_pkg::sat32(SW'(SW'($signed(lane[l].p)) >>> FRAC_BITS));
         cross_s[l] = v3alu_pkg::sat32(SW'($signed(SW'($signed(lane[l].p))
                                       - SW'($signed(lane[l].q))) >>> FRAC_BITS));
      end

      r2_in   = '0;
      rs2_in  = '0;
      sat2_in = 1'b0;
      nz2_in  = 1'b0;
      case (mode1_ff)
         v3alu_pkg::MODE_ADD, v3alu_pkg::MODE_SUB, v3alu_pkg::MODE_NEG: begin
            for (int l = 0; l < 3; l++) begin
               r2_in[l] = lane[l].simple;
               sat2_in  = sat2_in | lane[l].ovf;
            end
         end
         v3alu_pkg::MODE_SCALE: begin
            for (int l = 0; l < 3; l++) begin
               r2_in[l] = scale_s[l].val;
               sat2_in  = sat2_in | scale_s[l].ovf;
            end
         end
         v3alu_pkg::MODE_CROSS: begin
            for (int l = 0; l < 3; l++) begin
               r2_in[l] = cross_s[l].val;
               sat2_in  = sat2_in | cross_s[l].ovf;
            end
         end
         v3alu_pkg::MODE_DOT, v3alu_pkg::MODE_LENSQ: begin
            rs2_in  = dot_s.val;
            sat2_in = dot_s.ovf;
         end
         v3alu_pkg::MODE_REFLECT: sat2_in = t_s.ovf;
         v3alu_pkg::MODE_NEAR: begin
            nz2_in = lane[0].under_limit & lane[1].under_limit & lane[2].under_limit;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode2_ff <= mode1_ff;
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
      s2_ff    <= s1_ff;
      r2_ff    <= r2_in;
      rs2_ff   <= rs2_in;
      sat2_ff  <= sat2_in;
      nz2_ff   <= nz2_in;
      sq2_ff   <= sum_w[63:0];
      t2_ff    <= t_s.val;
   end

   // Reflect: b times twice the dot product
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rp3_in[l] = 64'($signed(b2_ff[l])) * 64'($signed(t2_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode3_ff <= mode2_ff;
      a3_ff    <= a2_ff;
      s3_ff    <= s2_ff;
      r3_ff    <= r2_ff;
      rs3_ff   <= rs2_ff;
      sat3_ff  <= sat2_ff;
      nz3_ff   <= nz2_ff;
      sq3_ff   <= sq2_ff;
      rp3_ff   <= rp3_in;
   end

   // Reflect finish, then into the square root
   always_comb begin
      sq_in_pay.mode = mode3_ff;
      sq_in_pay.a    = a3_ff;
      sq_in_pay.s    = s3_ff;
      sq_in_pay.r    = r3_ff;
      sq_in_pay.rs   = rs3_ff;
      sq_in_pay.sat  = sat3_ff;
      sq_in_pay.nz   = nz3_ff;
      for (int l = 0; l < 3; l++) begin
         refl_s[l] = v3alu_pkg::sat32(SW'($signed(SW'($signed(a3_ff[l]))
                     - (SW'($signed(rp3_ff[l])) >>> FRAC_BITS))));
      end
      if (mode3_ff == v3alu_pkg::MODE_REFLECT) begin
         for (int l = 0; l < 3; l++) begin
            sq_in_pay.r[l] = refl_s[l].val;
            sq_in_pay.sat  = sq_in_pay.sat | refl_s[l].ovf;
         end
      end
   end

   v3alu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .radicand  (sq3_ff),
      .in_pay    (sq_in_pay),
      .out_valid (sq_valid),
      .root      (root),
      .out_pay   (sq_out_pay)
   );

   // Length result, divisor pick and zero-divisor check
   always_comb begin
      s_mag          = sq_out_pay.s[31] ? (~sq_out_pay.s + 32'd1) : sq_out_pay.s;
      dv_in_pay.mode = sq_out_pay.mode;
      dv_in_pay.r    = sq_out_pay.r;
      dv_in_pay.rs   = sq_out_pay.rs;
      dv_in_pay.sat  = sq_out_pay.sat;
      dv_in_pay.nz   = sq_out_pay.nz;
      dv_in_pay.dz   = 1'b0;
      den            = root;
      den_neg        = 1'b0;
      if (sq_out_pay.mode == v3alu_pkg::MODE_LEN) begin
         dv_in_pay.rs  = root[31] ? v3alu_pkg::Q_MAX : root;
         dv_in_pay.sat = root[31];
      end
      if (sq_out_pay.mode == v3alu_pkg::MODE_DIV) begin
         den          = s_mag;
         den_neg      = sq_out_pay.s[31];
         dv_in_pay.dz = (sq_out_pay.s == '0);
      end
      if (sq_out_pay.mode == v3alu_pkg::MODE_NORM) begin
         dv_in_pay.dz = (root == '0);
      end
   end

   v3alu_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .num       (sq_out_pay.a),
      .den       (den),
      .den_neg   (den_neg),
      .in_pay    (dv_in_pay),
      .out_valid (dv_valid),
      .quo       (quo),
      .qsat      (qsat),
      .out_pay   (dv_out_pay)
   );

   // Final selection and status
   always_comb begin
      logic [2:0][31:0] fin_r;
      logic             fin_sat;
      rsp_in  = '0;
      fin_r   = dv_out_pay.r;
      fin_sat = dv_out_pay.sat;
      if (dv_out_pay.dz) begin
         rsp_in.status = v3alu_pkg::ST_DZ;
      end else begin
         if (dv_out_pay.mode inside {v3alu_pkg::MODE_DIV, v3alu_pkg::MODE_NORM}) begin
            fin_r   = quo;
            fin_sat = fin_sat | (|qsat);
         end
         rsp_in.res_x        = fin_r[0];
         rsp_in.res_y        = fin_r[1];
         rsp_in.res_z        = fin_r[2];
         rsp_in.res_scalar   = dv_out_pay.rs;
         rsp_in.is_near_zero = dv_out_pay.nz;
         rsp_in.status       = fin_sat ? v3alu_pkg::ST_SAT : v3alu_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted operation comes out after the fixed pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result strobe missing at fixed latency");

   // A divide status carries an all-zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == v3alu_pkg::ST_DZ) |->
      (rsp_data.res_x == '0 && rsp_data.res_y == '0 && rsp_data.res_z == '0 &&
       rsp_data.res_scalar == '0 && !rsp_data.is_near_zero))
      else $error("divide status with nonzero result");

   // A near-zero answer comes only with a clean, empty result
   a_near_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_near_zero) |->
      (rsp_data.status == v3alu_pkg::ST_OK && rsp_data.res_x == '0 &&
       rsp_data.res_y == '0 && rsp_data.res_z == '0 && rsp_data.res_scalar == '0))
      else $error("near-zero flag with other result content");

endmodule

`default_nettype wire
